[sv/lsu_pkg.sv]
// shared types, constants and the control store of the linked set union table
`default_nettype none

package lsu_pkg;

	localparam int ENTRIES    = 1024;
	localparam int CHUNK_BITS = 8;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int PTR_W      = IDX_W + 1;
	localparam int CNT_W      = IDX_W + 1;
	localparam int PC_W       = 4;

	localparam logic [PTR_W-1:0] END_MARK   = PTR_W'(ENTRIES);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_LINK = 1'b1;

	// branch conditions of the sequencer
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_START,
		COND_FAIL,
		COND_SAME,
		COND_END
	} cond_t;

	// datapath actions
	typedef enum logic [3:0] {
		ACT_IDLE,
		ACT_ADD,
		ACT_CHECK,
		ACT_RDB,
		ACT_RDCH,
		ACT_SAME,
		ACT_PICK,
		ACT_WALK,
		ACT_APPEND,
		ACT_RELABEL
	} act_t;

	typedef struct packed {
		logic            accept;
		logic            emit;
		cond_t           cond;
		act_t            act;
		logic [PC_W-1:0] target;
	} uop_t;

	typedef struct packed {
		logic in_valid;
		logic cmd;
		logic fail;
		logic same;
		logic nx_end;
		logic out_busy;
	} seq_flags_t;

	typedef struct packed {
		act_t act;
		logic run;
		logic emit;
		logic accept;
	} seq_ctrl_t;

	localparam logic [PC_W-1:0] ST_IDLE    = 4'd0;
	localparam logic [PC_W-1:0] ST_ADD     = 4'd1;
	localparam logic [PC_W-1:0] ST_LINK    = 4'd2;
	localparam logic [PC_W-1:0] ST_RDB     = 4'd3;
	localparam logic [PC_W-1:0] ST_RDCH    = 4'd4;
	localparam logic [PC_W-1:0] ST_SAME    = 4'd5;
	localparam logic [PC_W-1:0] ST_PICK    = 4'd6;
	localparam logic [PC_W-1:0] ST_WALK    = 4'd7;
	localparam logic [PC_W-1:0] ST_APPEND  = 4'd8;
	localparam logic [PC_W-1:0] ST_RELABEL = 4'd9;

	// control store: one word per step
	function automatic uop_t lsu_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{accept: 1'b0, emit: 1'b0, cond: COND_JUMP, act: ACT_IDLE, target: ST_IDLE};
		case (pc)
			ST_IDLE:    u = '{1'b1, 1'b0, COND_START, ACT_IDLE,    ST_LINK};
			ST_ADD:     u = '{1'b0, 1'b1, COND_JUMP,  ACT_ADD,     ST_IDLE};
			ST_LINK:    u = '{1'b0, 1'b1, COND_FAIL,  ACT_CHECK,   ST_IDLE};
			ST_RDB:     u = '{1'b0, 1'b0, COND_NEXT,  ACT_RDB,     ST_IDLE};
			ST_RDCH:    u = '{1'b0, 1'b0, COND_NEXT,  ACT_RDCH,    ST_IDLE};
			ST_SAME:    u = '{1'b0, 1'b1, COND_SAME,  ACT_SAME,    ST_IDLE};
			ST_PICK:    u = '{1'b0, 1'b0, COND_NEXT,  ACT_PICK,    ST_IDLE};
			ST_WALK:    u = '{1'b0, 1'b0, COND_END,   ACT_WALK,    ST_APPEND};
			ST_APPEND:  u = '{1'b0, 1'b0, COND_NEXT,  ACT_APPEND,  ST_IDLE};
			ST_RELABEL: u = '{1'b0, 1'b1, COND_END,   ACT_RELABEL, ST_IDLE};
			default:    u = '{1'b0, 1'b0, COND_JUMP,  ACT_IDLE,    ST_IDLE};
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

[sv/lsu_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module lsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/lsu_seq.sv]
// microcode sequencer: step counter, control store and branch logic
`default_nettype none

module lsu_seq
	import lsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire seq_flags_t flags,
	output seq_ctrl_t       ctrl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	uop_t            uop;
	logic            taken;
	logic            emit;
	logic            hold;

	always_comb begin
		uop     = lsu_rom(pc_q);
		taken   = 1'b0;
		pc_next = pc_q + PC_W'(1);
		case (uop.cond)
			COND_NEXT: begin
				pc_next = pc_q + PC_W'(1);
			end
			COND_JUMP: begin
				taken   = 1'b1;
				pc_next = uop.target;
			end
			COND_START: begin
				if (!flags.in_valid) begin
					pc_next = pc_q;
				end else if (flags.cmd == CMD_LINK) begin
					pc_next = uop.target;
				end
			end
			COND_FAIL: begin
				taken = flags.fail;
				if (taken) begin
					pc_next = uop.target;
				end
			end
			COND_SAME: begin
				taken = flags.same;
				if (taken) begin
					pc_next = uop.target;
				end
			end
			COND_END: begin
				taken   = flags.nx_end;
				pc_next = taken ? uop.target : pc_q;
			end
			default: begin
				pc_next = ST_IDLE;
			end
		endcase
		// a result can only leave when the output register is free
		emit        = uop.emit && taken;
		hold        = emit && flags.out_busy;
		ctrl.act    = uop.act;
		ctrl.run    = !hold;
		ctrl.emit   = emit && !hold;
		ctrl.accept = uop.accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (!hold) begin
			pc_q <= pc_next;
		end
	end

endmodule

`default_nettype wire

[sv/linked_set_union_table.sv]
// top level of the linked set union table: datapath, stores and result register
//  - request channel: in_valid / in_stall with cmd, chunk, first_index, second_index.
//    a request is taken on a rising edge with in_valid high and in_stall low.
//  - result channel: out_valid / out_stall with status, index, merged; one result
//    per request, taken on a rising edge with out_valid high and out_stall low.
//  - add (cmd 0): allocates the next entry as a one-member set, answers its index,
//    or status full once all entries are in use. the step right after the accept
//    loads the result register, holding while an earlier result still waits there.
//  - link (cmd 1): checks the indices, reads both heads and their chunks, tests for
//    one set and picks the winner, then walks the winning list from the winning
//    operand to its tail, appends the losing list and relabels its members; the
//    result is loaded once the relabel walk ends, or early for a bad index or when
//    both are in one set. every walk or relabel step uses one successor store read.
//  - the block works on one request at a time; in_stall is low only while the
//    sequencer sits at its idle step, so each request also passes through it.
//  - a finished result waits in the output register while the next request is
//    taken; if the receiver keeps stalling, the next result step holds until the
//    register frees up.
//  - reset clears the entry count, the sequencer and the output valid; the stores
//    need no clearing since data from unallocated entries is never used.
`default_nettype none

module linked_set_union_table
	import lsu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  cmd,
	input  wire logic [7:0]            chunk,
	input  wire logic [IDX_W-1:0]      first_index,
	input  wire logic [IDX_W-1:0]      second_index,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 status,
	output logic [IDX_W-1:0]           index,
	output logic                       merged
);

	seq_flags_t flags;
	seq_ctrl_t  ctrl;

	// request registers
	logic [CHUNK_BITS-1:0] chunk_q;
	logic [IDX_W-1:0]      a_q;
	logic [IDX_W-1:0]      b_q;

	// working registers
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      ha_q;
	logic [IDX_W-1:0]      hb_q;
	logic [CHUNK_BITS-1:0] cha_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [IDX_W-1:0]      wh_q;
	logic [IDX_W-1:0]      lh_q;

	// output register
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [IDX_W-1:0]      index_q;
	logic                  merged_q;

	// store ports
	logic                  head_we, head_re;
	logic [IDX_W-1:0]      head_waddr, head_raddr, head_wdata, head_rd;
	logic                  next_we, next_re;
	logic [IDX_W-1:0]      next_waddr, next_raddr;
	logic [PTR_W-1:0]      next_wdata, next_rd;
	logic                  chunk_we, chunk_re;
	logic [IDX_W-1:0]      chunk_waddr, chunk_raddr;
	logic [CHUNK_BITS-1:0] chunk_wdata, chunk_rd;

	logic                  full;
	logic                  nx_end;
	logic                  pick_b;
	logic [IDX_W-1:0]      nx_idx;

	// result candidate for the current step
	logic [1:0]            res_status;
	logic [IDX_W-1:0]      res_index;
	logic                  res_merged;

	lsu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	lsu_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (head_re),
		.raddr (head_raddr),
		.rdata (head_rd)
	);

	lsu_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (next_re),
		.raddr (next_raddr),
		.rdata (next_rd)
	);

	lsu_ram #(.WIDTH(CHUNK_BITS), .DEPTH(ENTRIES)) u_chunk_ram (
		.clk   (clk),
		.we    (chunk_we),
		.waddr (chunk_waddr),
		.wdata (chunk_wdata),
		.re    (chunk_re),
		.raddr (chunk_raddr),
		.rdata (chunk_rd)
	);

	assign full   = (count_q == FULL_COUNT);
	// successor at or beyond the table size ends a list
	assign nx_end = (next_rd >= END_MARK);
	assign nx_idx = next_rd[IDX_W-1:0];
	// lower chunk keeps headship, the first operand wins a tie
	assign pick_b = (cha_q > chunk_rd);

	always_comb begin
		flags.in_valid = in_valid;
		flags.cmd      = cmd;
		flags.fail     = ({1'b0, a_q} >= count_q) || ({1'b0, b_q} >= count_q);
		flags.same     = (a_q == b_q) || (ha_q == hb_q);
		flags.nx_end   = nx_end;
		flags.out_busy = out_valid_q && out_stall;
	end

	assign in_stall = !ctrl.accept;

	// store access per step
	always_comb begin
		head_we     = 1'b0;
		head_waddr  = '0;
		head_wdata  = '0;
		head_re     = 1'b0;
		head_raddr  = '0;
		next_we     = 1'b0;
		next_waddr  = '0;
		next_wdata  = '0;
		next_re     = 1'b0;
		next_raddr  = '0;
		chunk_we    = 1'b0;
		chunk_waddr = '0;
		chunk_wdata = '0;
		chunk_re    = 1'b0;
		chunk_raddr = '0;
		res_status  = STATUS_OK;
		res_index   = '0;
		res_merged  = 1'b0;
		case (ctrl.act)
			ACT_ADD: begin
				if (full) begin
					res_status = STATUS_FULL;
				end else begin
					// new one-member set: own head, no successor
					head_we     = ctrl.run;
					head_waddr  = count_q[IDX_W-1:0];
					head_wdata  = count_q[IDX_W-1:0];
					next_we     = ctrl.run;
					next_waddr  = count_q[IDX_W-1:0];
					next_wdata  = END_MARK;
					chunk_we    = ctrl.run;
					chunk_waddr = count_q[IDX_W-1:0];
					chunk_wdata = chunk_q;
					res_index   = count_q[IDX_W-1:0];
				end
			end
			ACT_CHECK: begin
				head_re    = ctrl.run;
				head_raddr = a_q;
				res_status = STATUS_BAD_INDEX;
			end
			ACT_RDB: begin
				head_re    = ctrl.run;
				head_raddr = b_q;
			end
			ACT_RDCH: begin
				chunk_re    = ctrl.run;
				chunk_raddr = ha_q;
			end
			ACT_SAME: begin
				chunk_re    = ctrl.run;
				chunk_raddr = hb_q;
				res_index   = ha_q;
			end
			ACT_PICK: begin
				next_re    = ctrl.run;
				next_raddr = pick_b ? b_q : a_q;
			end
			ACT_WALK: begin
				if (!nx_end) begin
					next_re    = ctrl.run;
					next_raddr = nx_idx;
				end
			end
			ACT_APPEND: begin
				// hang the losing list on the tail, relabel its head
				next_we    = ctrl.run;
				next_waddr = ptr_q;
				next_wdata = {1'b0, lh_q};
				head_we    = ctrl.run;
				head_waddr = lh_q;
				head_wdata = wh_q;
				next_re    = ctrl.run;
				next_raddr = lh_q;
			end
			ACT_RELABEL: begin
				if (!nx_end) begin
					head_we    = ctrl.run;
					head_waddr = nx_idx;
					head_wdata = wh_q;
					next_re    = ctrl.run;
					next_raddr = nx_idx;
				end
				res_index  = wh_q;
				res_merged = 1'b1;
			end
			default: begin
				res_status = STATUS_OK;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.run && ctrl.act == ACT_ADD && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (ctrl.run) begin
			case (ctrl.act)
				ACT_IDLE: begin
					if (in_valid) begin
						chunk_q <= chunk[CHUNK_BITS-1:0];
						a_q     <= first_index;
						b_q     <= second_index;
					end
				end
				ACT_RDB: begin
					ha_q <= head_rd;
				end
				ACT_RDCH: begin
					hb_q <= head_rd;
				end
				ACT_SAME: begin
					cha_q <= chunk_rd;
				end
				ACT_PICK: begin
					ptr_q <= pick_b ? b_q : a_q;
					wh_q  <= pick_b ? hb_q : ha_q;
					lh_q  <= pick_b ? ha_q : hb_q;
				end
				ACT_WALK: begin
					if (!nx_end) begin
						ptr_q <= nx_idx;
					end
				end
				default: begin
				end
			endcase
		end
		if (ctrl.emit) begin
			status_q <= res_status;
			index_q  <= res_index;
			merged_q <= res_merged;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign index     = index_q;
	assign merged    = merged_q;

endmodule

`default_nettype wire
